@@ rtl/core/uvs_pkg.sv @@
`timescale 1ns / 1ps

package uvs_pkg;

   localparam int MAX_RINGS    = 256;
   localparam int MAX_SEGMENTS = 256;
   localparam int MIN_SIZE     = 3;

   localparam int CFG_W     = 9;
   localparam int CSR_IDX_W = 8;
   localparam int IDX_W     = 16;
   localparam int POS_W     = 16;
   localparam int ANG_W     = 32;
   localparam int DIV_REM_W = CFG_W;

   localparam logic [CSR_IDX_W-1:0] CSR_RING_COUNT    = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_SEGMENT_COUNT = CSR_IDX_W'(1);
   localparam logic [CFG_W-1:0]     RING_COUNT_RESET    = CFG_W'(16);
   localparam logic [CFG_W-1:0]     SEGMENT_COUNT_RESET = CFG_W'(16);

   localparam logic OP_POINT = 1'b0;
   localparam logic OP_FACE  = 1'b1;

   localparam int DIV_STEPS     = IDX_W;
   localparam int ANG_DIV_STEPS = ANG_W;
   localparam int CORDIC_STEPS  = 16;
   localparam int ANG_LAT       = ANG_DIV_STEPS + CORDIC_STEPS + 1;

   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   localparam logic signed [POS_W-1:0] Q14_ONE   = 16'sd16384;
   localparam logic signed [ANG_W-1:0] CORDIC_X0 = 32'sd652032874;

   localparam logic signed [ANG_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
      32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
      32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
      32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
      32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861
   };

   typedef enum logic [2:0] {
      KIND_ERR,
      KIND_TOP_POLE,
      KIND_BOT_POLE,
      KIND_RING,
      KIND_TRI_TOP,
      KIND_TRI_BOT,
      KIND_QUAD
   } kind_type;

   typedef struct packed {
      logic             operation;
      logic [IDX_W-1:0] item_index;
   } req_type;

   typedef struct packed {
      logic                    status;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic [2:0]              corner_count;
      logic [IDX_W-1:0]        corner_a;
      logic [IDX_W-1:0]        corner_b;
      logic [IDX_W-1:0]        corner_c;
      logic [IDX_W-1:0]        corner_d;
   } rsp_type;

   typedef struct packed {
      kind_type         kind;
      logic [IDX_W-1:0] index;
      logic [IDX_W-1:0] dividend;
   } front_item_type;

   typedef struct packed {
      logic [CFG_W-1:0] rings;
      logic [CFG_W-1:0] segs;
      logic             bad;
      logic [IDX_W:0]   face_total;
      logic [IDX_W-1:0] base;
      logic [IDX_W-1:0] bottom;
   } geom_type;

   // one restoring step: returns {quotient bit, new remainder}
   function automatic logic [DIV_REM_W:0] div_step(logic [DIV_REM_W-1:0] rem,
                                                   logic bit_in,
                                                   logic [DIV_REM_W-1:0] divisor);
      logic [DIV_REM_W:0] t;
      logic               ge;
      t  = {rem, bit_in};
      ge = t >= {1'b0, divisor};
      div_step = {ge, ge ? DIV_REM_W'(t - {1'b0, divisor}) : t[DIV_REM_W-1:0]};
   endfunction

endpackage

@@ rtl/core/uvs_front.sv @@
`timescale 1ns / 1ps

module uvs_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  uvs_pkg::req_type        req_data,
   input  uvs_pkg::geom_type       geom,
   input  logic                    mid_pop,
   output logic                    mid_empty,
   output uvs_pkg::front_item_type mid_item
);
   import uvs_pkg::*;

   front_item_type         cls;
   front_item_type         q_mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [Q_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [IDX_W-1:0]       n;
   logic                   push;

   assign n = req_data.item_index;

   always_comb begin
      cls          = '0;
      cls.index    = n;
      cls.kind     = KIND_ERR;
      cls.dividend = '0;
      if (geom.bad) begin
         cls.kind = KIND_ERR;
      end else if (req_data.operation == OP_POINT) begin
         if (n > geom.bottom) begin
            cls.kind = KIND_ERR;
         end else if (n == '0) begin
            cls.kind = KIND_TOP_POLE;
         end else if (n == geom.bottom) begin
            cls.kind = KIND_BOT_POLE;
         end else begin
            cls.kind     = KIND_RING;
            cls.dividend = n - IDX_W'(1);
         end
      end else begin
         if ({1'b0, n} >= geom.face_total) begin
            cls.kind = KIND_ERR;
         end else if ({1'b0, n} < (IDX_W+1)'({geom.segs, 1'b0})) begin
            cls.kind = n[0] ? KIND_TRI_BOT : KIND_TRI_TOP;
         end else begin
            cls.kind     = KIND_QUAD;
            cls.dividend = n - IDX_W'({geom.segs, 1'b0});
         end
      end
   end

   assign req_full  = cnt_ff == Q_CNT_W'(Q_DEPTH);
   assign mid_empty = cnt_ff == '0;
   assign mid_item  = q_mem_ff[rd_ptr_ff];
   assign push      = req_push && !req_full;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !mid_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!push && mid_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (mid_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

@@ rtl/core/uvs_divider.sv @@
`timescale 1ns / 1ps

module uvs_divider (
   input  logic                            clock,
   input  logic                            en,
   input  logic [uvs_pkg::IDX_W-1:0]       dividend,
   input  logic [uvs_pkg::DIV_REM_W-1:0]   divisor,
   output logic [uvs_pkg::IDX_W-1:0]       quotient,
   output logic [uvs_pkg::DIV_REM_W-1:0]   remainder
);
   import uvs_pkg::*;

   logic [IDX_W-1:0]     word_ff [DIV_STEPS];
   logic [DIV_REM_W-1:0] rem_ff  [DIV_STEPS];
   logic [IDX_W-1:0]     word_in [DIV_STEPS];
   logic [DIV_REM_W-1:0] rem_in  [DIV_STEPS];

   // one quotient bit per stage, dividend bits shift out as quotient bits shift in
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      logic [IDX_W-1:0]     w_prev;
      logic [DIV_REM_W-1:0] r_prev;
      logic [DIV_REM_W:0]   step;
      if (k == 0) begin : g_first
         assign w_prev = dividend;
         assign r_prev = '0;
      end else begin : g_next
         assign w_prev = word_ff[k-1];
         assign r_prev = rem_ff[k-1];
      end
      assign step       = div_step(r_prev, w_prev[IDX_W-1], divisor);
      assign word_in[k] = {w_prev[IDX_W-2:0], step[DIV_REM_W]};
      assign rem_in[k]  = step[DIV_REM_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         word_ff <= word_in;
         rem_ff  <= rem_in;
      end
   end

   assign quotient  = word_ff[DIV_STEPS-1];
   assign remainder = rem_ff[DIV_STEPS-1];

endmodule

@@ rtl/core/uvs_angle.sv @@
`timescale 1ns / 1ps

module uvs_angle (
   input  logic                                clock,
   input  logic                                en,
   input  logic [uvs_pkg::DIV_REM_W-1:0]       rem_init,
   input  logic [uvs_pkg::ANG_W-1:0]           low_bits,
   input  logic [uvs_pkg::DIV_REM_W-1:0]       divisor,
   output logic signed [uvs_pkg::ANG_W-1:0]    cos_q30,
   output logic signed [uvs_pkg::ANG_W-1:0]    sin_q30
);
   import uvs_pkg::*;

   // angle code = ({rem_init, low_bits} + 0) / divisor, one bit per stage
   logic [ANG_W-1:0]            word_ff [ANG_DIV_STEPS];
   logic [DIV_REM_W-1:0]        rem_ff  [ANG_DIV_STEPS];
   logic [ANG_W-1:0]            word_in [ANG_DIV_STEPS];
   logic [DIV_REM_W-1:0]        rem_in  [ANG_DIV_STEPS];

   logic signed [ANG_W-1:0]     cx_ff [CORDIC_STEPS];
   logic signed [ANG_W-1:0]     cy_ff [CORDIC_STEPS];
   logic signed [ANG_W-1:0]     cz_ff [CORDIC_STEPS];
   logic [1:0]                  cq_ff [CORDIC_STEPS];
   logic signed [ANG_W-1:0]     cx_in [CORDIC_STEPS];
   logic signed [ANG_W-1:0]     cy_in [CORDIC_STEPS];
   logic signed [ANG_W-1:0]     cz_in [CORDIC_STEPS];
   logic [1:0]                  cq_in [CORDIC_STEPS];

   logic signed [ANG_W-1:0]     cos_ff, sin_ff, cos_in, sin_in;
   logic signed [ANG_W-1:0]     fx, fy;

   for (genvar k = 0; k < ANG_DIV_STEPS; k++) begin : g_div
      logic [ANG_W-1:0]     w_prev;
      logic [DIV_REM_W-1:0] r_prev;
      logic [DIV_REM_W:0]   step;
      if (k == 0) begin : g_first
         assign w_prev = low_bits;
         assign r_prev = rem_init;
      end else begin : g_next
         assign w_prev = word_ff[k-1];
         assign r_prev = rem_ff[k-1];
      end
      assign step       = div_step(r_prev, w_prev[ANG_W-1], divisor);
      assign word_in[k] = {w_prev[ANG_W-2:0], step[DIV_REM_W]};
      assign rem_in[k]  = step[DIV_REM_W-1:0];
   end

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
      logic signed [ANG_W-1:0] px, py, pz;
      logic [1:0]              pq;
      logic signed [ANG_W-1:0] dx, dy;
      if (k == 0) begin : g_first
         // top two bits pick the quadrant, the rest is the residual angle
         assign px = CORDIC_X0;
         assign py = '0;
         assign pz = signed'({2'b00, word_ff[ANG_DIV_STEPS-1][ANG_W-3:0]});
         assign pq = word_ff[ANG_DIV_STEPS-1][ANG_W-1:ANG_W-2];
      end else begin : g_next
         assign px = cx_ff[k-1];
         assign py = cy_ff[k-1];
         assign pz = cz_ff[k-1];
         assign pq = cq_ff[k-1];
      end
      assign dx       = py >>> k;
      assign dy       = px >>> k;
      assign cx_in[k] = pz[ANG_W-1] ? px + dx : px - dx;
      assign cy_in[k] = pz[ANG_W-1] ? py - dy : py + dy;
      assign cz_in[k] = pz[ANG_W-1] ? pz + ATAN_TURNS[k] : pz - ATAN_TURNS[k];
      assign cq_in[k] = pq;
   end

   assign fx = cx_ff[CORDIC_STEPS-1];
   assign fy = cy_ff[CORDIC_STEPS-1];

   always_comb begin
      unique case (cq_ff[CORDIC_STEPS-1])
         2'd0: begin
            cos_in = fx;
            sin_in = fy;
         end
         2'd1: begin
            cos_in = -fy;
            sin_in = fx;
         end
         2'd2: begin
            cos_in = -fx;
            sin_in = -fy;
         end
         default: begin
            cos_in = fy;
            sin_in = -fx;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         word_ff <= word_in;
         rem_ff  <= rem_in;
         cx_ff   <= cx_in;
         cy_ff   <= cy_in;
         cz_ff   <= cz_in;
         cq_ff   <= cq_in;
         cos_ff  <= cos_in;
         sin_ff  <= sin_in;
      end
   end

   assign cos_q30 = cos_ff;
   assign sin_q30 = sin_ff;

endmodule

@@ rtl/core/uvs_back.sv @@
`timescale 1ns / 1ps

module uvs_back (
   input  logic                    clock,
   input  logic                    reset,
   input  uvs_pkg::geom_type       geom,
   input  logic                    mid_empty,
   input  uvs_pkg::front_item_type mid_item,
   output logic                    mid_pop,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output uvs_pkg::rsp_type        rsp_data
);
   import uvs_pkg::*;

   typedef struct packed {
      kind_type         kind;
      logic [IDX_W-1:0] index;
   } side_a_type;

   typedef struct packed {
      kind_type         kind;
      logic [2:0]       cnt;
      logic [IDX_W-1:0] ca;
      logic [IDX_W-1:0] cb;
      logic [IDX_W-1:0] cc;
      logic [IDX_W-1:0] cd;
   } side_b_type;

   function automatic logic signed [POS_W-1:0] sat14(logic signed [63:0] v);
      logic signed [63:0] one;
      one = 64'(Q14_ONE);
      if (v > one) begin
         sat14 = Q14_ONE;
      end else if (v < -one) begin
         sat14 = -Q14_ONE;
      end else begin
         sat14 = POS_W'(v);
      end
   endfunction

   logic                    en;
   logic [DIV_STEPS-1:0]    a_vld_ff;
   side_a_type              a_ff [DIV_STEPS];
   logic [ANG_LAT-1:0]      b_vld_ff;
   side_b_type              b_ff [ANG_LAT];
   side_b_type              b_in;
   logic                    c_vld_ff;
   side_b_type              c_ff;

   logic [IDX_W-1:0]        quo;
   logic [DIV_REM_W-1:0]    rem;
   side_a_type              sa;
   logic [DIV_REM_W-1:0]    ring_p1, phi_rem, fi, fnx, fi_p1;
   logic [ANG_W-1:0]        phi_low, th_low;
   logic [IDX_W-1:0]        j0, j1;
   logic                    tri_face;

   logic signed [ANG_W-1:0] cos_phi, sin_phi, cos_th, sin_th;
   logic signed [63:0]      prod_x_ff, prod_z_ff;
   logic signed [ANG_W-1:0] cos_phi_ff;
   logic signed [63:0]      y_sum, x_sum, z_sum;
   rsp_type                 rsp_in;

   rsp_type                 out_mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]      out_wr_ff, out_rd_ff;
   logic [Q_CNT_W-1:0]      out_cnt_ff, out_cnt_in;
   logic                    push, pop;

   // the whole pipe moves only while the result queue has a free slot
   assign en      = out_cnt_ff != Q_CNT_W'(Q_DEPTH);
   assign mid_pop = en && !mid_empty;

   uvs_divider u_div (
      .clock     (clock),
      .en        (en),
      .dividend  (mid_item.dividend),
      .divisor   (geom.segs),
      .quotient  (quo),
      .remainder (rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= '0;
         b_vld_ff <= '0;
         c_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff <= {a_vld_ff[DIV_STEPS-2:0], mid_pop};
         b_vld_ff <= {b_vld_ff[ANG_LAT-2:0], a_vld_ff[DIV_STEPS-1]};
         c_vld_ff <= b_vld_ff[ANG_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff[0] <= '{kind: mid_item.kind, index: mid_item.index};
         for (int k = 1; k < DIV_STEPS; k++) begin
            a_ff[k] <= a_ff[k-1];
         end
         b_ff[0] <= b_in;
         for (int k = 1; k < ANG_LAT; k++) begin
            b_ff[k] <= b_ff[k-1];
         end
         c_ff <= b_ff[ANG_LAT-1];
      end
   end

   // ring = quotient, column = remainder; quads reuse them as row and column
   assign sa       = a_ff[DIV_STEPS-1];
   assign ring_p1  = DIV_REM_W'(quo) + DIV_REM_W'(1);
   assign phi_rem  = {1'b0, ring_p1[DIV_REM_W-1:1]};
   assign phi_low  = {ring_p1[0], (ANG_W-1)'(geom.rings >> 1)};
   assign th_low   = ANG_W'(geom.segs >> 1);
   assign tri_face = (sa.kind == KIND_TRI_TOP) || (sa.kind == KIND_TRI_BOT);
   assign fi       = tri_face ? sa.index[DIV_REM_W:1] : rem;
   assign fi_p1    = fi + DIV_REM_W'(1);
   assign fnx      = (fi_p1 == geom.segs) ? '0 : fi_p1;
   assign j0       = IDX_W'(quo * IDX_W'(geom.segs)) + IDX_W'(1);
   assign j1       = j0 + IDX_W'(geom.segs);

   always_comb begin
      b_in      = '0;
      b_in.kind = sa.kind;
      unique case (sa.kind)
         KIND_TRI_TOP: begin
            b_in.cnt = 3'd3;
            b_in.ca  = IDX_W'(fnx) + IDX_W'(1);
            b_in.cb  = IDX_W'(fi) + IDX_W'(1);
         end
         KIND_TRI_BOT: begin
            b_in.cnt = 3'd3;
            b_in.ca  = geom.bottom;
            b_in.cb  = IDX_W'(fi) + geom.base;
            b_in.cc  = IDX_W'(fnx) + geom.base;
         end
         KIND_QUAD: begin
            b_in.cnt = 3'd4;
            b_in.ca  = j0 + IDX_W'(fi);
            b_in.cb  = j0 + IDX_W'(fnx);
            b_in.cc  = j1 + IDX_W'(fnx);
            b_in.cd  = j1 + IDX_W'(fi);
         end
         default: begin
            b_in.cnt = 3'd0;
         end
      endcase
   end

   uvs_angle u_phi (
      .clock    (clock),
      .en       (en),
      .rem_init (phi_rem),
      .low_bits (phi_low),
      .divisor  (geom.rings),
      .cos_q30  (cos_phi),
      .sin_q30  (sin_phi)
   );

   uvs_angle u_theta (
      .clock    (clock),
      .en       (en),
      .rem_init (rem),
      .low_bits (th_low),
      .divisor  (geom.segs),
      .cos_q30  (cos_th),
      .sin_q30  (sin_th)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         prod_x_ff  <= 64'(sin_phi) * 64'(cos_th);
         prod_z_ff  <= 64'(sin_phi) * 64'(sin_th);
         cos_phi_ff <= cos_phi;
      end
   end

   // round half up, then back to Q1.14
   assign y_sum = (64'(cos_phi_ff) + 64'sd32768) >>> 16;
   assign x_sum = (prod_x_ff + 64'sh0000_2000_0000_0000) >>> 46;
   assign z_sum = (prod_z_ff + 64'sh0000_2000_0000_0000) >>> 46;

   always_comb begin
      rsp_in = '0;
      unique case (c_ff.kind)
         KIND_ERR: begin
            rsp_in.status = 1'b1;
         end
         KIND_TOP_POLE: begin
            rsp_in.pos_y = Q14_ONE;
         end
         KIND_BOT_POLE: begin
            rsp_in.pos_y = -Q14_ONE;
         end
         KIND_RING: begin
            rsp_in.pos_x = sat14(x_sum);
            rsp_in.pos_y = sat14(y_sum);
            rsp_in.pos_z = sat14(z_sum);
         end
         KIND_TRI_TOP, KIND_TRI_BOT, KIND_QUAD: begin
            rsp_in.corner_count = c_ff.cnt;
            rsp_in.corner_a     = c_ff.ca;
            rsp_in.corner_b     = c_ff.cb;
            rsp_in.corner_c     = c_ff.cc;
            rsp_in.corner_d     = c_ff.cd;
         end
         default: begin
            rsp_in.status = 1'b1;
         end
      endcase
   end

   assign push      = c_vld_ff && en;
   assign rsp_empty = out_cnt_ff == '0;
   assign pop       = rsp_pop && !rsp_empty;
   assign rsp_data  = out_mem_ff[out_rd_ff];

   always_comb begin
      out_cnt_in = out_cnt_ff;
      if (push && !pop) begin
         out_cnt_in = out_cnt_ff + 1'b1;
      end else if (!push && pop) begin
         out_cnt_in = out_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ff  <= '0;
         out_rd_ff  <= '0;
         out_cnt_ff <= '0;
      end else begin
         out_cnt_ff <= out_cnt_in;
         if (push) begin
            out_wr_ff <= (out_wr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : out_wr_ff + 1'b1;
         end
         if (pop) begin
            out_rd_ff <= (out_rd_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : out_rd_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         out_mem_ff[out_wr_ff] <= rsp_in;
      end
   end

   a_out_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      out_cnt_ff <= Q_CNT_W'(Q_DEPTH))
      else $error("result queue count beyond depth");

   a_pipe_frozen: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(c_vld_ff) && $stable(b_vld_ff) && $stable(a_vld_ff))
      else $error("pipe moved while result queue full");

   a_err_no_corners: assert property (@(posedge clock) disable iff (reset)
      push && rsp_in.status |-> rsp_in.corner_count == 3'd0 && rsp_in.pos_y == '0)
      else $error("error word carries payload");

   a_tri_no_fourth: assert property (@(posedge clock) disable iff (reset)
      push && rsp_in.corner_count == 3'd3 |-> rsp_in.corner_d == '0)
      else $error("triangle with fourth corner");

endmodule

@@ rtl/core/uv_sphere_point_and_face_generator_core.sv @@
`timescale 1ns / 1ps
// channel   ports                               word
// req       req_push / req_full                 operation, item_index
// rsp       rsp_empty / rsp_pop                 status, pos_x/y/z, corner_count, corners
// csr       csr_valid / csr_ready (always set)  csr_index, csr_data
//
// one request is taken per cycle while req_full is low, and one word leaves per cycle while rsp_pop stays high
// the path runs through 16 index divide steps, 32 angle divide steps, 16 cordic
// steps, quadrant map, multiply, and the two queues
// reset is synchronous; both sizes come back as 16
// a full result queue freezes the whole back pipe; the input queue then fills and
// raises req_full

module uv_sphere_point_and_face_generator_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  uvs_pkg::req_type                req_data,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output uvs_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [uvs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [uvs_pkg::CFG_W-1:0]       csr_data
);
   import uvs_pkg::*;

   logic [CFG_W-1:0] ring_count_ff, segment_count_ff;
   logic [CFG_W-1:0] rings, segs;
   geom_type         geom;
   front_item_type   mid_item;
   logic             mid_empty, mid_pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_count_ff    <= RING_COUNT_RESET;
         segment_count_ff <= SEGMENT_COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_RING_COUNT:    ring_count_ff    <= csr_data;
            CSR_SEGMENT_COUNT: segment_count_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign rings = (ring_count_ff > CFG_W'(MAX_RINGS)) ? CFG_W'(MAX_RINGS) : ring_count_ff;
   assign segs  = (segment_count_ff > CFG_W'(MAX_SEGMENTS)) ?
                  CFG_W'(MAX_SEGMENTS) : segment_count_ff;

   always_comb begin
      geom            = '0;
      geom.rings      = rings;
      geom.segs       = segs;
      geom.bad        = (rings < CFG_W'(MIN_SIZE)) || (segs < CFG_W'(MIN_SIZE));
      geom.face_total = (IDX_W+1)'(rings) * (IDX_W+1)'(segs);
      // first point of the last ring, and the bottom pole just after it
      geom.base       = IDX_W'((IDX_W+1)'(rings - CFG_W'(2)) * (IDX_W+1)'(segs)
                               + (IDX_W+1)'(1));
      geom.bottom     = geom.base + IDX_W'(segs);
   end

   uvs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .geom      (geom),
      .mid_pop   (mid_pop),
      .mid_empty (mid_empty),
      .mid_item  (mid_item)
   );

   uvs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .geom      (geom),
      .mid_empty (mid_empty),
      .mid_item  (mid_item),
      .mid_pop   (mid_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
